// ----- design/mls_pkg.sv -----
// Shared types, character codes and helpers for the marker line stripper.
// No dependencies; every other design file imports this package.
`default_nettype none

package mls_pkg;

    localparam int MLS_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // One queued request: n_held bytes of the "!!*" prefix, then an optional tail result.
    typedef struct packed {
        logic [1:0] n_held;
        logic       has_tail;
        logic       tail_kind;
        logic [7:0] tail_byte;
    } cmd_t;

    // Byte at a given place of the held prefix "!!*".
    function automatic logic [7:0] held_char(input logic [1:0] idx);
        logic [7:0] ch;
        ch = (idx == 2'd2) ? CH_STAR : CH_BANG;
        return ch;
    endfunction

endpackage : mls_pkg

`default_nettype wire

// ----- design/marker_line_stripper_unit.sv -----
// Top level of the marker line stripper: front end, request queue, back end.
// Depends on mls_pkg, mls_front, mls_queue and mls_back.
//
// Usage:
//   Input channel (item_valid / item_stall / item) carries one text byte or an
//   end-of-stream flag per request. Output channel (result_valid / result_stall /
//   result) carries kept bytes and the end marker; last_of_run closes the results
//   of one input request.
//   Runs starting with "!!**" are deleted through the next LF, CR or CR LF.
// Path: a taken input is written into the request queue, then loaded into the
//   output register once the back end reaches it.
// Throughput: one input per cycle while result_stall is low and each input
//   yields at most one result. The back end writes one result per unstalled
//   cycle, so an input releasing up to four results holds it until all are out;
//   the QUEUE_DEPTH-entry queue absorbs bursts; item_stall rises only when full.
// Stall: while result_stall is high the output register holds; the back end
//   waits and the queue fills, then the input is stalled.
// Reset: the match state returns to idle, the queue empties and no result is
//   valid. There is no clearing pass.
`default_nettype none

module marker_line_stripper_unit #(
    parameter int QUEUE_DEPTH = mls_pkg::MLS_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire mls_pkg::in_item_t  item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output mls_pkg::out_item_t      result
);
    import mls_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic head_valid;
    logic full;

    // Stall the source only while the queue has no room.
    assign item_stall = full;
    assign accept     = item_valid && !full;

    mls_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .cmd    (push_cmd)
    );

    mls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    mls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule : marker_line_stripper_unit

`default_nettype wire

// ----- design/mls_front.sv -----
// Front end: marker match state machine that classifies each input item into a request.
// Depends on mls_pkg.
`default_nettype none

module mls_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire mls_pkg::in_item_t item,
    output logic                  push,
    output mls_pkg::cmd_t         cmd
);
    import mls_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_RM,
        ST_RMCR
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [7:0] b;

    assign b = item.data_byte;

    always_comb
    begin
        state_next    = state_reg;
        cmd.n_held    = 2'd0;
        cmd.has_tail  = 1'b0;
        cmd.tail_kind = KIND_TEXT;
        cmd.tail_byte = b;
        if (item.stream_end)
        begin
            // Flush the held prefix, then the end marker.
            unique case (state_reg)
                ST_H1:   cmd.n_held = 2'd1;
                ST_H2:   cmd.n_held = 2'd2;
                ST_H3:   cmd.n_held = 2'd3;
                default: cmd.n_held = 2'd0;
            endcase
            cmd.has_tail  = 1'b1;
            cmd.tail_kind = KIND_END;
            cmd.tail_byte = 8'd0;
            state_next    = ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_H1:
                begin
                    if (b == CH_BANG)
                    begin
                        state_next = ST_H2;
                    end
                    else
                    begin
                        cmd.n_held   = 2'd1;
                        cmd.has_tail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                ST_H2:
                begin
                    if (b == CH_STAR)
                    begin
                        state_next = ST_H3;
                    end
                    else if (b == CH_BANG)
                    begin
                        // Oldest bang leaves, the window stays at "!!".
                        cmd.n_held = 2'd1;
                    end
                    else
                    begin
                        cmd.n_held   = 2'd2;
                        cmd.has_tail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                ST_H3:
                begin
                    if (b == CH_STAR)
                    begin
                        state_next = ST_RM;
                    end
                    else
                    begin
                        cmd.n_held = 2'd3;
                        if (b == CH_BANG)
                        begin
                            state_next = ST_H1;
                        end
                        else
                        begin
                            cmd.has_tail = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                end
                ST_RM:
                begin
                    if (b == CH_LF)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (b == CH_CR)
                    begin
                        state_next = ST_RMCR;
                    end
                end
                ST_RMCR:
                begin
                    if (b == CH_LF)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (b == CH_BANG)
                    begin
                        state_next = ST_H1;
                    end
                    else
                    begin
                        cmd.has_tail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default:
                begin
                    if (b == CH_BANG)
                    begin
                        state_next = ST_H1;
                    end
                    else
                    begin
                        cmd.has_tail = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Drop requests that produce no result.
    assign push = accept && ((cmd.n_held != 2'd0) || cmd.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule : mls_front

`default_nettype wire

// ----- design/mls_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on mls_pkg for the request type.
`default_nettype none

module mls_queue #(
    parameter int DEPTH = mls_pkg::MLS_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mls_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output mls_pkg::cmd_t      head,
    output logic               head_valid,
    output logic               full
);
    import mls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");

endmodule : mls_queue

`default_nettype wire

// ----- design/mls_back.sv -----
// Back end: expands each queued request into result items in an output register,
// one per cycle while result_stall is low. Depends on mls_pkg.
`default_nettype none

module mls_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mls_pkg::cmd_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               result_valid,
    input  wire logic          result_stall,
    output mls_pkg::out_item_t result
);
    import mls_pkg::*;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [2:0] total;
    logic       last;
    logic       load;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_reg;
    out_item_t  out_next;

    assign total = {1'b0, head.n_held} + {2'b00, head.has_tail};
    assign last  = ({1'b0, pos_reg} + 3'd1) == total;
    assign load  = head_valid && (!out_valid_reg || !result_stall);
    assign pop   = load && last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            pos_next       = last ? 2'd0 : pos_reg + 2'd1;
            if (pos_reg < head.n_held)
            begin
                out_next.out_kind = KIND_TEXT;
                out_next.out_byte = held_char(pos_reg);
            end
            else
            begin
                out_next.out_kind = head.tail_kind;
                out_next.out_byte = head.tail_byte;
            end
            out_next.last_of_run = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (total != 3'd0))
        else $error("empty request reached the back end");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, pos_reg} < total))
        else $error("result index past end of request");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (pos_reg == 2'd0))
        else $error("result index left set with queue empty");

endmodule : mls_back

`default_nettype wire

// ----- bench/marker_line_stripper_unit_tb.sv -----
// Self-checking bench for marker_line_stripper_unit: directed table, then random requests.
// Depends on mls_pkg and the design files; results are predicted inside the bench itself.
`default_nettype none

module marker_line_stripper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mls_pkg::*;

    // Match progress of the stripper as seen from the bench.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE_BANG,
        S_TWO_BANG,
        S_BANG_STAR,
        S_DROP,
        S_DROP_CR
    } strip_state_t;

    // One row of the directed table. When known is set, want is the single result
    // that the request must produce; otherwise the predictor supplies the results.
    typedef struct packed {
        in_item_t  req;
        logic      known;
        out_item_t want;
    } dir_row_t;

    function automatic dir_row_t row_pred(input logic [7:0] b, input logic e);
        dir_row_t r;
        r = '0;
        r.req.data_byte  = b;
        r.req.stream_end = e;
        return r;
    endfunction

    function automatic dir_row_t row_known(input logic [7:0] b, input logic e,
                                           input logic kind, input logic [7:0] ob);
        dir_row_t r;
        r = row_pred(b, e);
        r.known            = 1'b1;
        r.want.out_kind    = kind;
        r.want.out_byte    = ob;
        r.want.last_of_run = 1'b1;
        return r;
    endfunction

    localparam int DIR_ROWS = 25;

    // Directed walk: field extremes, a full marker line, CR followed by CR,
    // overlapping prefix, end while dropping right after a CR, a failed "!!*"
    // prefix that re-arms on its last byte, and end while holding three bytes.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        row_known(8'h41, 1'b0, KIND_TEXT, 8'h41),   // plain byte right after reset
        row_known(8'h00, 1'b0, KIND_TEXT, 8'h00),
        row_known(8'hFF, 1'b0, KIND_TEXT, 8'hFF),
        row_known(8'h00, 1'b1, KIND_END,  8'h00),   // end with nothing held
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_STAR, 1'b0),
        row_pred (CH_STAR, 1'b0),                   // marker complete, start dropping
        row_pred (CH_CR,   1'b0),                   // CR closes the run
        row_known(CH_CR,   1'b0, KIND_TEXT, CH_CR), // second CR is plain text
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_BANG, 1'b0),                   // "!!!" releases one bang
        row_pred (CH_STAR, 1'b0),
        row_pred (CH_STAR, 1'b0),
        row_pred (CH_CR,   1'b0),
        row_known(8'h5A,   1'b1, KIND_END,  8'h00), // end swallows the pending CR
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_STAR, 1'b0),
        row_pred (CH_BANG, 1'b0),                   // "!!*" fails, new bang is held
        row_pred (CH_BANG, 1'b0),
        row_pred (CH_STAR, 1'b0),
        row_pred (8'hFF,   1'b1),                   // end flushes "!!*" then end mark
        row_known(8'h7A,   1'b0, KIND_TEXT, 8'h7A)
    };

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    marker_line_stripper_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Predictor state and the results still owed by the block, oldest first.
    strip_state_t strip_st;
    out_item_t    burst[$];
    out_item_t    due_results[$];
    in_item_t     byte_backlog[$];

    int send_idle_pct;
    int stall_pct;
    int sent_count;
    int flush_count;
    int checked_count;
    int end_marks_seen;
    int fault_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void emit_result(input logic kind, input logic [7:0] b);
        out_item_t r;
        r.out_kind    = kind;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        burst.push_back(r);
    endfunction

    // Release the first n bytes of the held "!!*" prefix.
    function automatic void emit_prefix(input int n);
        for (int i = 0; i < n; i++)
            emit_result(KIND_TEXT, (i == 2) ? CH_STAR : CH_BANG);
    endfunction

    // Treat a byte as if nothing were held: a bang arms the matcher, anything
    // else passes straight through.
    function automatic void take_fresh(input logic [7:0] b);
        if (b == CH_BANG)
            strip_st = S_ONE_BANG;
        else
        begin
            emit_result(KIND_TEXT, b);
            strip_st = S_IDLE;
        end
    endfunction

    // Work out the results of one accepted request into burst.
    function automatic void predict_strip(input in_item_t req);
        logic [7:0] b;
        out_item_t  tail;
        b = req.data_byte;
        burst.delete();
        if (req.stream_end)
        begin
            case (strip_st)
                S_ONE_BANG:  emit_prefix(1);
                S_TWO_BANG:  emit_prefix(2);
                S_BANG_STAR: emit_prefix(3);
                default:     ;
            endcase
            emit_result(KIND_END, 8'h00);
            strip_st = S_IDLE;
        end
        else
        begin
            case (strip_st)
                S_ONE_BANG:
                    if (b == CH_BANG)
                        strip_st = S_TWO_BANG;
                    else
                    begin
                        emit_prefix(1);
                        take_fresh(b);
                    end
                S_TWO_BANG:
                    if (b == CH_STAR)
                        strip_st = S_BANG_STAR;
                    else if (b == CH_BANG)
                        emit_result(KIND_TEXT, CH_BANG);  // slide the window by one
                    else
                    begin
                        emit_prefix(2);
                        emit_result(KIND_TEXT, b);
                        strip_st = S_IDLE;
                    end
                S_BANG_STAR:
                    if (b == CH_STAR)
                        strip_st = S_DROP;
                    else
                    begin
                        emit_prefix(3);
                        take_fresh(b);
                    end
                S_DROP:
                    if (b == CH_LF)
                        strip_st = S_IDLE;
                    else if (b == CH_CR)
                        strip_st = S_DROP_CR;
                S_DROP_CR:
                    if (b == CH_LF)
                        strip_st = S_IDLE;
                    else
                        take_fresh(b);
                default:
                    take_fresh(b);
            endcase
        end
        if (burst.size() > 0)
        begin
            tail = burst.pop_back();
            tail.last_of_run = 1'b1;
            burst.push_back(tail);
        end
    endfunction

    function automatic void book_burst();
        foreach (burst[i])
            due_results.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Random request generation
    // ------------------------------------------------------------------

    function automatic void queue_byte(input logic [7:0] b, input logic e);
        in_item_t r;
        r.data_byte  = b;
        r.stream_end = e;
        byte_backlog.push_back(r);
    endfunction

    function automatic void queue_str(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], 1'b0);
    endfunction

    function automatic void queue_line_end();
        case ($urandom_range(2))
            0: queue_byte(CH_LF, 1'b0);
            1: queue_byte(CH_CR, 1'b0);
            default:
            begin
                queue_byte(CH_CR, 1'b0);
                queue_byte(CH_LF, 1'b0);
            end
        endcase
    endfunction

    // Mostly printable body text, with the occasional arbitrary byte.
    function automatic void queue_body(input int max_len);
        repeat ($urandom_range(max_len))
        begin
            if ($urandom_range(4) == 0)
                queue_byte(8'($urandom_range(255)), 1'b0);
            else
                queue_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        end
    endfunction

    // Append one segment of text: a well-formed marker line with random content,
    // plain text, a near-miss prefix, a bare line end or an end-of-stream request
    // in an awkward place.
    function automatic void queue_segment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            repeat ($urandom_range(6, 1))
                queue_byte(8'($urandom_range(255)), 1'b0);
        else if (pick < 55)
        begin
            if ($urandom_range(3) == 0)
                queue_str("!!!**");
            else
                queue_str("!!**");
            queue_body(5);
            queue_line_end();
        end
        else if (pick < 72)
        begin
            case ($urandom_range(5))
                0: queue_str("!");
                1: queue_str("!!");
                2: queue_str("!!*");
                3: queue_str("!!!");
                4: queue_str("!!!*");
                default: queue_str("!!*!");
            endcase
            queue_byte(8'($urandom_range(255)), 1'b0);
        end
        else if (pick < 82)
        begin
            queue_line_end();
            queue_body(3);
        end
        else if (pick < 92)
        begin
            // marker line closed by CR, then something other than LF
            queue_str("!!**");
            queue_body(4);
            queue_byte(CH_CR, 1'b0);
            case ($urandom_range(2))
                0: queue_byte(CH_CR, 1'b0);
                1: queue_byte(CH_BANG, 1'b0);
                default: queue_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
            endcase
        end
        else
        begin
            case ($urandom_range(3))
                0: ;
                1: queue_str("!!**ab");
                2:
                begin
                    queue_str("!!**");
                    queue_byte(CH_CR, 1'b0);
                end
                default: queue_str("!!*");
            endcase
            queue_byte(8'($urandom_range(255)), 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it.
    task automatic issue(input in_item_t r);
        item_valid <= 1'b1;
        item       <= r;
        do @(posedge clk); while (item_stall);
        sent_count++;
        if (r.stream_end)
            flush_count++;
    endtask

    // Now and then drop valid and idle until a random draw ends the gap. Once valid
    // is dropped the clock always advances before the test, so valid is never lowered and raised in the same step.
    task automatic sender_gap();
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check each accepted result and randomize stall
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                if (fault_count < 10)
                    $display("%0t: unexpected result kind=%0d byte=%02h last=%0d",
                             $realtime, result.out_kind, result.out_byte,
                             result.last_of_run);
                fault_count++;
            end
            else
            begin
                want = due_results.pop_front();
                checked_count++;
                if (want.out_kind == KIND_END)
                    end_marks_seen++;
                if (result.out_kind !== want.out_kind ||
                    result.out_byte !== want.out_byte ||
                    result.last_of_run !== want.last_of_run)
                begin
                    if (fault_count < 10)
                        $display({"%0t: mismatch, expected kind=%0d byte=%02h last=%0d, ",
                                  "got kind=%0d byte=%02h last=%0d"},
                                 $realtime, want.out_kind, want.out_byte,
                                 want.last_of_run, result.out_kind, result.out_byte,
                                 result.last_of_run);
                    fault_count++;
                end
            end
        end
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        in_item_t req;
        int       phase_stop;

        strip_st       = S_IDLE;
        send_idle_pct  = 0;
        stall_pct      = 0;
        sent_count     = 0;
        flush_count    = 0;
        checked_count  = 0;
        end_marks_seen = 0;
        fault_count    = 0;

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        result_stall <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; known rows replace the prediction with the typed value.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            issue(DIR_TABLE[i].req);
            predict_strip(DIR_TABLE[i].req);
            if (DIR_TABLE[i].known)
                due_results.push_back(DIR_TABLE[i].want);
            else
                book_burst();
        end
        hold_until_drained();

        // Random traffic in four idling phases, about a hundred requests each.
        // Each phase ends with the sender held until the output side is empty.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 53;
                end
                default:
                begin
                    send_idle_pct = 30;
                    stall_pct     = 30;
                end
            endcase
            phase_stop = sent_count + 100;
            while (sent_count < phase_stop)
            begin
                if (byte_backlog.size() == 0)
                    queue_segment();
                sender_gap();
                req = byte_backlog.pop_front();
                issue(req);
                predict_strip(req);
                book_burst();
            end
            hold_until_drained();
        end

        // Let any stray result show up before the verdict.
        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0d results never arrived", due_results.size());
            fault_count++;
        end

        $display("sent %0d requests (%0d directed, %0d stream ends), checked %0d results",
                 sent_count, DIR_ROWS, flush_count, checked_count);
        $display("end marks seen %0d, failures %0d", end_marks_seen, fault_count);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: end the run with a failure if the main sequence has not finished first.
    initial
    begin
        #4_000_000;
        $display("timeout waiting for the block");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule : marker_line_stripper_unit_tb

`default_nettype wire
